@@ sv/flv_stream_tag_deframer_core_assert.svh @@
// ---------------------------------------------------------------------------
// flv stream tag deframer assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef FLV_STREAM_TAG_DEFRAMER_CORE_ASSERT_SVH
`define FLV_STREAM_TAG_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsd check failed");
`define FSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsd check failed");
`else
`define FSD_ASSERT_SAME(lbl, ante, cons)
`define FSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/fsd_pkg.sv @@
// ---------------------------------------------------------------------------
// fsd_pkg
// shared beat types, parser phases and format constants
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsd_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  payload_byte;
        logic [4:0]  tag_type;
        logic [31:0] tag_time;
        logic [23:0] tag_length;
        logic        last_of_tag;
        logic [1:0]  stream_kind;
    } out_beat_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PREV    = 2'd1,
        PH_TAGHDR  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_RESTART = 1'b1;

    localparam logic [1:0] EV_HEADER_OK = 2'd0;
    localparam logic [1:0] EV_PAYLOAD   = 2'd1;
    localparam logic [1:0] EV_EMPTY_TAG = 2'd2;
    localparam logic [1:0] EV_ERROR     = 2'd3;

    localparam logic [1:0] SK_NONE  = 2'd0;
    localparam logic [1:0] SK_AUDIO = 2'd1;
    localparam logic [1:0] SK_VIDEO = 2'd2;
    localparam logic [1:0] SK_BOTH  = 2'd3;

    localparam logic [7:0] SIG_F       = 8'h46;
    localparam logic [7:0] SIG_L       = 8'h4C;
    localparam logic [7:0] SIG_V       = 8'h56;
    localparam logic [7:0] FLV_VERSION = 8'h01;
    localparam logic [7:0] AUDIO_FLAG  = 8'h04;
    localparam logic [7:0] VIDEO_FLAG  = 8'h01;

    localparam logic [23:0] HDR_FLAGS_IDX = 24'd4;
    localparam logic [23:0] HDR_LAST_IDX  = 24'd8;
    localparam logic [23:0] PREV_LAST_IDX = 24'd3;
    localparam logic [23:0] TAG_LAST_IDX  = 24'd10;

endpackage

@@ sv/fsd_front.sv @@
// ---------------------------------------------------------------------------
// fsd_front
// byte parser: tracks header, previous-size, tag header and payload phases
// and builds one result beat per byte that yields one
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  fsd_pkg::in_beat_t  item,
    output logic               wr_en,
    output fsd_pkg::out_beat_t wr_beat
);
    import fsd_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [23:0] count_reg,  count_next;
    logic        sig_ok_reg, sig_ok_next;
    logic [4:0]  type_reg,   type_next;
    logic [23:0] length_reg, length_next;
    logic [31:0] time_reg,   time_next;
    logic [1:0]  skind_reg,  skind_next;
    logic        failed_reg, failed_next;

    logic [7:0]  b;
    logic        restart;
    logic        active;
    logic        pay_last;

    assign b        = item.data_byte;
    assign restart  = accept && (item.kind == KIND_RESTART);
    assign active   = accept && (item.kind == KIND_DATA) && !failed_reg;
    assign pay_last = ({1'b0, count_reg} + 25'd1) >= {1'b0, length_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (restart)
        begin
            phase_next = PH_HEADER;
        end
        else if (active)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (count_reg >= HDR_LAST_IDX && sig_ok_reg)
                        phase_next = PH_PREV;
                end
                PH_PREV:
                begin
                    if (count_reg >= PREV_LAST_IDX)
                        phase_next = PH_TAGHDR;
                end
                PH_TAGHDR:
                begin
                    if (count_reg >= TAG_LAST_IDX)
                        phase_next = (length_reg == 24'd0) ? PH_PREV : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (pay_last)
                        phase_next = PH_PREV;
                end
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    // field state and result beat
    always_comb
    begin
        count_next  = count_reg;
        sig_ok_next = sig_ok_reg;
        type_next   = type_reg;
        length_next = length_reg;
        time_next   = time_reg;
        skind_next  = skind_reg;
        failed_next = failed_reg;
        wr_en       = 1'b0;
        wr_beat     = '0;

        if (restart)
        begin
            count_next  = '0;
            sig_ok_next = 1'b1;
            type_next   = '0;
            length_next = '0;
            time_next   = '0;
            skind_next  = SK_NONE;
            failed_next = 1'b0;
        end
        else if (active)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if ((count_reg == 24'd0 && b != SIG_F) ||
                        (count_reg == 24'd1 && b != SIG_L) ||
                        (count_reg == 24'd2 && b != SIG_V) ||
                        (count_reg == 24'd3 && b != FLV_VERSION))
                        sig_ok_next = 1'b0;
                    if (count_reg == HDR_FLAGS_IDX && sig_ok_reg)
                        skind_next = {(b & VIDEO_FLAG) != 8'd0, (b & AUDIO_FLAG) != 8'd0};
                    if (count_reg >= HDR_LAST_IDX)
                    begin
                        count_next = '0;
                        wr_en      = 1'b1;
                        if (sig_ok_reg)
                        begin
                            wr_beat.event_res   = EV_HEADER_OK;
                            wr_beat.stream_kind = skind_reg;
                        end
                        else
                        begin
                            failed_next         = 1'b1;
                            skind_next          = SK_NONE;
                            wr_beat.event_res   = EV_ERROR;
                            wr_beat.stream_kind = SK_NONE;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 24'd1;
                    end
                end
                PH_PREV:
                begin
                    count_next = (count_reg >= PREV_LAST_IDX) ? 24'd0 : count_reg + 24'd1;
                end
                PH_TAGHDR:
                begin
                    if (count_reg[23:3] == 21'd0)
                    begin
                        unique case (count_reg[2:0])
                            3'd0:
                            begin
                                type_next   = b[4:0];
                                length_next = '0;
                                time_next   = '0;
                            end
                            3'd1: length_next[23:16] = b;
                            3'd2: length_next[15:8]  = b;
                            3'd3: length_next[7:0]   = b;
                            3'd4: time_next[23:16]   = b;
                            3'd5: time_next[15:8]    = b;
                            3'd6: time_next[7:0]     = b;
                            3'd7: time_next[31:24]   = b;
                            default: type_next = type_reg;
                        endcase
                    end
                    if (count_reg >= TAG_LAST_IDX)
                    begin
                        count_next = '0;
                        if (length_reg == 24'd0)
                        begin
                            wr_en               = 1'b1;
                            wr_beat.event_res   = EV_EMPTY_TAG;
                            wr_beat.tag_type    = type_reg;
                            wr_beat.tag_time    = time_reg;
                            wr_beat.tag_length  = length_reg;
                            wr_beat.last_of_tag = 1'b1;
                            wr_beat.stream_kind = skind_reg;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 24'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr_en                = 1'b1;
                    wr_beat.event_res    = EV_PAYLOAD;
                    wr_beat.payload_byte = b;
                    wr_beat.tag_type     = type_reg;
                    wr_beat.tag_time     = time_reg;
                    wr_beat.tag_length   = length_reg;
                    wr_beat.last_of_tag  = pay_last;
                    wr_beat.stream_kind  = skind_reg;
                    count_next = pay_last ? 24'd0 : count_reg + 24'd1;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            count_reg  <= '0;
            sig_ok_reg <= 1'b1;
            type_reg   <= '0;
            length_reg <= '0;
            time_reg   <= '0;
            skind_reg  <= SK_NONE;
            failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            sig_ok_reg <= sig_ok_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            time_reg   <= time_next;
            skind_reg  <= skind_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ sv/fsd_queue.sv @@
// ---------------------------------------------------------------------------
// fsd_queue
// small result queue between the parser and the result port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  fsd_pkg::out_beat_t wr_beat,
    input  logic               rd_en,
    output fsd_pkg::out_beat_t rd_beat,
    output logic               full,
    output logic               empty
);
    import fsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    out_beat_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_wr;
    logic            do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_beat = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/flv_stream_tag_deframer_core.sv @@
// FLV tag deframer: takes one stream byte per cycle while full is low and returns header
// verdicts, tagged payload bytes and empty-tag markers, each built by the byte parser
// and registered into the queue. Parsed results wait in a DEPTH-beat queue, so push
// stays open until DEPTH results wait unpopped; full rises only once DEPTH results are waiting.
// A restart beat sends the parser back to the file header and gives no result.
// ---------------------------------------------------------------------------
// flv_stream_tag_deframer_core
// top level: byte parser in front, result queue behind it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module flv_stream_tag_deframer_core #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  fsd_pkg::in_beat_t  item,
    output logic               empty,
    input  logic               pop,
    output fsd_pkg::out_beat_t result
);
    import fsd_pkg::*;

    logic      accept;
    logic      wr_en;
    out_beat_t wr_beat;

    assign accept = push && !full;

    fsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .wr_en   (wr_en),
        .wr_beat (wr_beat)
    );

    fsd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_beat (wr_beat),
        .rd_en   (pop),
        .rd_beat (result),
        .full    (full),
        .empty   (empty)
    );

`include "flv_stream_tag_deframer_core_assert.svh"

    // results only come from accepted beats
    `FSD_ASSERT_NEXT(a_no_spurious, empty && !accept, empty)
    // a restart beat never produces a result
    `FSD_ASSERT_NEXT(a_restart_silent, empty && accept && item.kind == KIND_RESTART, empty)
    // header verdicts carry no tag attributes
    `FSD_ASSERT_SAME(a_hdr_untagged, !empty && (result.event_res == EV_HEADER_OK || result.event_res == EV_ERROR), result.tag_length == 24'd0 && !result.last_of_tag)
    // empty-tag events always close their tag
    `FSD_ASSERT_SAME(a_empty_tag_last, !empty && result.event_res == EV_EMPTY_TAG, result.last_of_tag && result.tag_length == 24'd0)

endmodule
